/* design/rcdt_pkg.sv */
// Shared types, constants and arithmetic helpers of the RGB chase trail dither engine.
package rcdt_pkg;

    localparam int LVL_W   = 16;
    localparam int RES_W   = 8;
    localparam int CODE_W  = 8;
    localparam int IDX_W   = 6;
    localparam int FADE_W  = 16;
    localparam int MOVE_W  = 8;
    localparam int SEGF_W  = 15;
    localparam int FRAME_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W   = 32;
    localparam int DVS_W   = 16;

    localparam logic [FADE_W-1:0]  FADE_RESET = 16'd64820;
    localparam logic [MOVE_W-1:0]  MOVE_RESET = 8'd12;
    localparam logic [SEGF_W-1:0]  SEG_RESET  = 15'd1000;
    localparam logic [SEGF_W-1:0]  SEG_MIN    = 15'd2;
    localparam logic [SEGF_W-1:0]  SEG_MAX    = 15'd21845;
    localparam logic [LVL_W-1:0]   FULL_Q8    = 16'hFF00;
    localparam logic [31:0]        ROUND_HALF = 32'h0000_8000;
    localparam logic [CODE_W-1:0]  CODE_MAX   = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE = 2'd0,
        CFG_MOVE = 2'd1,
        CFG_SEG  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_POS,
        S_DIV_T,
        S_RD,
        S_MUL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SEG_RG,
        SEG_GB,
        SEG_BR
    } t_seg;

    typedef struct packed {
        logic [LVL_W-1:0] r_lvl;
        logic [LVL_W-1:0] g_lvl;
        logic [LVL_W-1:0] b_lvl;
        logic [RES_W-1:0] r_res;
        logic [RES_W-1:0] g_res;
        logic [RES_W-1:0] b_res;
    } t_led_word;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

    // Q16 fade with round to nearest; the sum never exceeds 32 bits.
    function automatic logic [LVL_W-1:0] decay(input logic [LVL_W-1:0] v,
                                               input logic [FADE_W-1:0] fs);
        logic [31:0] prod;
        prod = v * fs + ROUND_HALF;
        return prod[31:16];
    endfunction

    // Error-diffusion step: returns {code, new residue}. At full scale the carry is dropped.
    function automatic logic [CODE_W+RES_W-1:0] quantize(input logic [LVL_W-1:0] v,
                                                         input logic [RES_W-1:0] res);
        logic [RES_W:0]    sum;
        logic [CODE_W-1:0] whole;
        sum   = {1'b0, v[7:0]} + {1'b0, res};
        whole = v[15:8];
        if (sum[RES_W] && (whole != CODE_MAX)) begin
            whole = whole + 8'd1;
        end
        return {whole, sum[RES_W-1:0]};
    endfunction

endpackage

/* design/rcdt_if.sv */
// Handshake channel interfaces: frame ticks in, pixels out, register writes.
interface rcdt_in_if;
    logic valid;
    logic ready;
    logic frame_tick;
    modport source (output valid, output frame_tick, input ready);
    modport sink   (input valid, input frame_tick, output ready);
endinterface

interface rcdt_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
    modport source (output valid, output led_index, output red, output green,
                    output blue, output last_pixel, input ready);
    modport sink   (input valid, input led_index, input red, input green,
                    input blue, input last_pixel, output ready);
endinterface

interface rcdt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/rgb_chase_trail_dither_engine.sv */
// Top level of the RGB chase trail dither engine: frame sequencer, LED store and output stage.
//
// Each accepted frame_tick of 1 produces LED_COUNT pixel transactions in index order, the last
// one flagged with last_pixel; a frame_tick of 0 is taken and ignored. A frame first runs two
// 32-step divisions on a shared bit-serial divider (colour frame by segment length, then the
// segment position scaled to Q8.8 by segment length minus one), then walks the LED store
// one LED at a time (memory read, fade multiply, quantize and write back); a stalled sink
// stretches the walk. Levels and residues of all LEDs live in one single-port memory word
// per LED; per-LED valid bits make the store read as zero after reset, so no clearing pass
// is needed. A new frame tick is taken once the last pixel of the previous frame has been
// loaded into the output register. Register writes are taken at any time.
module rgb_chase_trail_dither_engine #(
    parameter int LED_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rcdt_in_if.sink           i_in,
    rcdt_out_if.source        o_out,
    rcdt_cfg_if.sink          i_cfg
);

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(LED_COUNT - 1);

    // Configuration registers.
    logic [rcdt_pkg::FADE_W-1:0] r_fade;
    logic [rcdt_pkg::MOVE_W-1:0] r_move;
    logic [rcdt_pkg::SEGF_W-1:0] r_segf;

    // Frame state.
    rcdt_pkg::t_state             r_state, n_state;
    logic [rcdt_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic [AW-1:0]                r_head, n_head;
    logic [rcdt_pkg::MOVE_W-1:0]  r_phase, n_phase;
    logic [AW-1:0]                r_idx, n_idx;
    rcdt_pkg::t_seg               r_seg, n_seg;
    logic [rcdt_pkg::LVL_W-1:0]   r_src_r, r_src_g, r_src_b;

    // LED store.
    rcdt_pkg::t_led_word          mem [LED_COUNT];
    logic [LED_COUNT-1:0]         r_valid;
    rcdt_pkg::t_led_word          r_rd_data;
    logic                         r_rd_valid;
    rcdt_pkg::t_led_word          wr_word;
    logic                         mem_we;

    logic [rcdt_pkg::LVL_W-1:0]   r_dec_r, r_dec_g, r_dec_b;
    logic [rcdt_pkg::RES_W-1:0]   r_res_r, r_res_g, r_res_b;

    // Output register.
    logic                         r_out_valid;
    logic [rcdt_pkg::IDX_W-1:0]   r_out_idx;
    logic [rcdt_pkg::CODE_W-1:0]  r_out_r, r_out_g, r_out_b;
    logic                         r_out_last;
    logic                         out_load;
    logic                         out_free;

    rcdt_pkg::t_div_req           div_req;
    rcdt_pkg::t_div_rsp           div_rsp;

    logic [rcdt_pkg::SEGF_W-1:0]  seg;
    logic [rcdt_pkg::SEGF_W-1:0]  steps;
    logic [rcdt_pkg::FRAME_W:0]   seg3;
    logic [rcdt_pkg::DIV_W-1:0]   t_dividend;
    logic [rcdt_pkg::LVL_W-1:0]   t_val;
    logic                         tick_acc;

    logic [rcdt_pkg::LVL_W-1:0]   lvl_r, lvl_g, lvl_b;
    logic [rcdt_pkg::CODE_W+rcdt_pkg::RES_W-1:0] q_r, q_g, q_b;

    rcdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        seg = r_segf;
        if (r_segf < rcdt_pkg::SEG_MIN) begin
            seg = rcdt_pkg::SEG_MIN;
        end else if (r_segf > rcdt_pkg::SEG_MAX) begin
            seg = rcdt_pkg::SEG_MAX;
        end
    end

    assign steps = seg - 1'b1;
    assign seg3  = {2'b00, seg} + {1'b0, seg, 1'b0};

    // pos * 65280 + steps / 2, with pos the remainder of the first division.
    assign t_dividend = {div_rsp.remainder, 16'h0000}
                      - {8'h00, div_rsp.remainder, 8'h00}
                      + {18'h0, steps[rcdt_pkg::SEGF_W-1:1]};
    assign t_val      = div_rsp.quotient[rcdt_pkg::LVL_W-1:0];

    assign tick_acc = i_in.valid && i_in.ready && i_in.frame_tick;
    assign i_in.ready  = (r_state == rcdt_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade <= rcdt_pkg::FADE_RESET;
            r_move <= rcdt_pkg::MOVE_RESET;
            r_segf <= rcdt_pkg::SEG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rcdt_pkg::CFG_FADE: r_fade <= i_cfg.data;
                rcdt_pkg::CFG_MOVE: r_move <= i_cfg.data[rcdt_pkg::MOVE_W-1:0];
                rcdt_pkg::CFG_SEG:  r_segf <= i_cfg.data[rcdt_pkg::SEGF_W-1:0];
                default: ;
            endcase
        end
    end

    // The head LED takes the source colour after the fade.
    assign lvl_r = (r_idx == r_head) ? r_src_r : r_dec_r;
    assign lvl_g = (r_idx == r_head) ? r_src_g : r_dec_g;
    assign lvl_b = (r_idx == r_head) ? r_src_b : r_dec_b;
    assign q_r   = rcdt_pkg::quantize(lvl_r, r_res_r);
    assign q_g   = rcdt_pkg::quantize(lvl_g, r_res_g);
    assign q_b   = rcdt_pkg::quantize(lvl_b, r_res_b);

    assign wr_word.r_lvl = lvl_r;
    assign wr_word.g_lvl = lvl_g;
    assign wr_word.b_lvl = lvl_b;
    assign wr_word.r_res = q_r[rcdt_pkg::RES_W-1:0];
    assign wr_word.g_res = q_g[rcdt_pkg::RES_W-1:0];
    assign wr_word.b_res = q_b[rcdt_pkg::RES_W-1:0];

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state  = r_state;
        n_frame  = r_frame;
        n_head   = r_head;
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_seg    = r_seg;
        div_req.start    = 1'b0;
        div_req.dividend = {16'h0000, r_frame};
        div_req.divisor  = {1'b0, seg};
        mem_we   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            rcdt_pkg::S_IDLE: begin
                if (tick_acc) begin
                    div_req.start = 1'b1;
                    n_state = rcdt_pkg::S_DIV_POS;
                end
            end
            rcdt_pkg::S_DIV_POS: begin
                div_req.dividend = t_dividend;
                div_req.divisor  = {1'b0, steps};
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    if (div_rsp.quotient == 32'd0) begin
                        n_seg = rcdt_pkg::SEG_RG;
                    end else if (div_rsp.quotient == 32'd1) begin
                        n_seg = rcdt_pkg::SEG_GB;
                    end else begin
                        n_seg = rcdt_pkg::SEG_BR;
                    end
                    n_state = rcdt_pkg::S_DIV_T;
                end
            end
            rcdt_pkg::S_DIV_T: begin
                if (div_rsp.done) begin
                    n_idx   = '0;
                    n_state = rcdt_pkg::S_RD;
                end
            end
            rcdt_pkg::S_RD: begin
                n_state = rcdt_pkg::S_MUL;
            end
            rcdt_pkg::S_MUL: begin
                n_state = rcdt_pkg::S_OUT;
            end
            rcdt_pkg::S_OUT: begin
                if (out_free) begin
                    mem_we   = 1'b1;
                    out_load = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_phase = r_phase + 1'b1;
                        if (n_phase >= r_move) begin
                            n_phase = '0;
                            n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                        end
                        n_frame = r_frame + 1'b1;
                        if ({1'b0, n_frame} >= seg3) begin
                            n_frame = '0;
                        end
                        n_state = rcdt_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = rcdt_pkg::S_RD;
                    end
                end
            end
            default: n_state = rcdt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcdt_pkg::S_IDLE;
            r_frame     <= '0;
            r_head      <= '0;
            r_phase     <= '0;
            r_idx       <= '0;
            r_seg       <= rcdt_pkg::SEG_RG;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_frame <= n_frame;
            r_head  <= n_head;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_seg   <= n_seg;
            if (mem_we) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Source colour for the head LED, set once the scaled position is known.
    always_ff @(posedge i_clk) begin
        if ((r_state == rcdt_pkg::S_DIV_T) && div_rsp.done) begin
            case (r_seg)
                rcdt_pkg::SEG_RG: begin
                    r_src_r <= rcdt_pkg::FULL_Q8 - t_val;
                    r_src_g <= t_val;
                    r_src_b <= '0;
                end
                rcdt_pkg::SEG_GB: begin
                    r_src_r <= '0;
                    r_src_g <= rcdt_pkg::FULL_Q8 - t_val;
                    r_src_b <= t_val;
                end
                default: begin
                    r_src_r <= t_val;
                    r_src_g <= '0;
                    r_src_b <= rcdt_pkg::FULL_Q8 - t_val;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= wr_word;
        end
        r_rd_data  <= mem[r_idx];
        r_rd_valid <= r_valid[r_idx];
    end

    // An entry never written since reset reads as all zero.
    always_ff @(posedge i_clk) begin
        if (r_state == rcdt_pkg::S_MUL) begin
            if (r_rd_valid) begin
                r_dec_r <= rcdt_pkg::decay(r_rd_data.r_lvl, r_fade);
                r_dec_g <= rcdt_pkg::decay(r_rd_data.g_lvl, r_fade);
                r_dec_b <= rcdt_pkg::decay(r_rd_data.b_lvl, r_fade);
                r_res_r <= r_rd_data.r_res;
                r_res_g <= r_rd_data.g_res;
                r_res_b <= r_rd_data.b_res;
            end else begin
                r_dec_r <= '0;
                r_dec_g <= '0;
                r_dec_b <= '0;
                r_res_r <= '0;
                r_res_g <= '0;
                r_res_b <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx  <= rcdt_pkg::IDX_W'(r_idx);
            r_out_r    <= q_r[rcdt_pkg::CODE_W+rcdt_pkg::RES_W-1:rcdt_pkg::RES_W];
            r_out_g    <= q_g[rcdt_pkg::CODE_W+rcdt_pkg::RES_W-1:rcdt_pkg::RES_W];
            r_out_b    <= q_b[rcdt_pkg::CODE_W+rcdt_pkg::RES_W-1:rcdt_pkg::RES_W];
            r_out_last <= (r_idx == LAST_IDX);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.led_index  = r_out_idx;
    assign o_out.red        = r_out_r;
    assign o_out.green      = r_out_g;
    assign o_out.blue       = r_out_b;
    assign o_out.last_pixel = r_out_last;

endmodule

/* design/rcdt_div.sv */
// Restoring divider, one quotient bit per cycle, quotient and remainder held after done.
module rcdt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcdt_pkg::t_div_req i_req,
    output rcdt_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(rcdt_pkg::DIV_W);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [rcdt_pkg::DIV_W-1:0]   r_quo;
    logic [rcdt_pkg::DVS_W-1:0]   r_rem;
    logic [rcdt_pkg::DVS_W-1:0]   r_dvs;

    logic [rcdt_pkg::DVS_W:0]     shifted;
    logic [rcdt_pkg::DVS_W:0]     diff;
    logic                         fits;

    assign shifted = {r_rem, r_quo[rcdt_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(rcdt_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[rcdt_pkg::DIV_W-2:0], fits};
            r_rem <= fits ? diff[rcdt_pkg::DVS_W-1:0] : shifted[rcdt_pkg::DVS_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule
